// File: rtl/core/source_text_lexer_defines.svh
// assertion macros shared by the lexer rtl
`ifndef SOURCE_TEXT_LEXER_DEFINES_SVH
`define SOURCE_TEXT_LEXER_DEFINES_SVH

`ifndef SYNTHESIS
// plain property checked on every clock edge out of reset
`define STL_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("stl assertion failed");
// same-cycle implication
`define STL_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stl implication failed");
// next-cycle implication
`define STL_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stl next-cycle implication failed");
`else
`define STL_ASSERT(name, clk, rst_n, prop)
`define STL_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define STL_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/core/stl_pkg.sv
// shared types and constants of the source text lexer
`default_nettype none

package stl_pkg;

  // token kinds
  localparam logic [2:0] KIND_INT   = 3'd0;
  localparam logic [2:0] KIND_NAME  = 3'd1;
  localparam logic [2:0] KIND_STR   = 3'd2;
  localparam logic [2:0] KIND_PUNCT = 3'd3;
  localparam logic [2:0] KIND_EOF   = 3'd4;
  localparam logic [2:0] KIND_ERR   = 3'd5;

  // error codes
  localparam logic [2:0] ERR_ESC_END    = 3'd0;
  localparam logic [2:0] ERR_BAD_ESC    = 3'd1;
  localparam logic [2:0] ERR_UNTERM     = 3'd2;
  localparam logic [2:0] ERR_NAME_LONG  = 3'd3;
  localparam logic [2:0] ERR_UNEXPECTED = 3'd4;
  localparam logic [2:0] ERR_STR_LONG   = 3'd5;

  // characters with a meaning of their own
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_T  = 8'h74;

  localparam int unsigned IntW = 31;

  // byte classification flags
  typedef struct packed {
    logic alpha;
    logic digit;
    logic punct;
    logic space;
    logic lf;
    logic hash;
    logic quote;
    logic bslash;
  } class_t;

endpackage

`default_nettype wire

// File: rtl/core/stl_if.sv
// valid/ready channel interfaces for source bytes and token results
`default_nettype none

interface stl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_text;

  modport source (output valid, output byte_in, output end_of_text, input ready);
  modport sink (input valid, input byte_in, input end_of_text, output ready);
endinterface

interface stl_out_if #(
  parameter int unsigned LINE_BITS = 20,
  parameter int unsigned COL_BITS  = 16
);
  logic                 valid;
  logic                 ready;
  logic [2:0]           token_kind;
  logic                 has_char;
  logic [7:0]           char_out;
  logic [30:0]          int_value;
  logic [LINE_BITS-1:0] tok_line;
  logic [COL_BITS-1:0]  tok_col;
  logic [2:0]           err_code;
  logic                 tok_last;

  modport source (
    output valid, output token_kind, output has_char, output char_out,
    output int_value, output tok_line, output tok_col, output err_code,
    output tok_last, input ready
  );
  modport sink (
    input valid, input token_kind, input has_char, input char_out,
    input int_value, input tok_line, input tok_col, input err_code,
    input tok_last, output ready
  );
endinterface

`default_nettype wire

// File: rtl/core/stl_class.sv
// byte classifier: character sets of the lexer
`default_nettype none

module stl_class
  import stl_pkg::*;
(
  input  logic [7:0] byte_i,
  output class_t     cls_o
);

  always_comb begin
    cls_o        = '0;
    cls_o.alpha  = (byte_i inside {[8'h61:8'h7A], [8'h41:8'h5A]}) || (byte_i == CH_USCORE);
    cls_o.digit  = byte_i inside {[8'h30:8'h39]};
    cls_o.space  = (byte_i == CH_SPACE) || (byte_i == CH_TAB) || (byte_i == CH_CR);
    cls_o.lf     = byte_i == CH_LF;
    cls_o.hash   = byte_i == CH_HASH;
    cls_o.quote  = byte_i == CH_QUOTE;
    cls_o.bslash = byte_i == CH_BSLASH;
    // ( ) { } [ ] $ , . : ? \ !
    case (byte_i) inside
      8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h24, 8'h2C, 8'h2E, 8'h3A, 8'h3F,
      8'h5C, 8'h21: cls_o.punct = 1'b1;
      default:      cls_o.punct = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/stl_res_fifo.sv
// small result queue taking up to two entries a cycle and giving one while the reader is ready
`default_nettype none

`include "source_text_lexer_defines.svh"

module stl_res_fifo #(
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        push_cnt_i,
  input  logic [DATA_W-1:0] data0_i,
  input  logic [DATA_W-1:0] data1_i,
  output logic              room_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] out_data_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [DATA_W-1:0] mem_q [Depth];
  logic [PtrW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              pop;

  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem_q[rptr_q];
  assign pop         = out_valid_o && out_ready_i;
  // room for a full pair, decided on the registered fill only
  assign room_o      = cnt_q <= CntW'(Depth - 2);

  assign wptr_d = wptr_q + PtrW'(push_cnt_i);
  assign rptr_d = rptr_q + PtrW'(pop);
  assign cnt_d  = cnt_q + CntW'(push_cnt_i) - CntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wptr_q] <= data0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wptr_q + PtrW'(1)] <= data1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  `STL_ASSERT(a_fill_bound, clk_i, rst_ni, cnt_q <= CntW'(Depth))
  `STL_ASSERT(a_push_code, clk_i, rst_ni, push_cnt_i != 2'd3)
  `STL_ASSERT_IMP(a_push_room, clk_i, rst_ni, push_cnt_i != 2'd0, room_o)

endmodule

`default_nettype wire

// File: rtl/core/stl_core.sv
// lexer state, per-byte step logic and result queue
`default_nettype none

`include "source_text_lexer_defines.svh"

module stl_core
  import stl_pkg::*;
#(
  parameter int unsigned MAX_NAME_LEN   = 255,
  parameter int unsigned MAX_STRING_LEN = 4095,
  parameter int unsigned LINE_BITS      = 20,
  parameter int unsigned COL_BITS       = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       item_valid_i,
  input  logic [7:0] byte_i,
  input  logic       eot_i,
  input  class_t     cls_i,
  output logic       take_o,
  stl_out_if.source  out_o
);

  localparam int unsigned MaxLen = (MAX_NAME_LEN > MAX_STRING_LEN) ? MAX_NAME_LEN
                                                                   : MAX_STRING_LEN;
  localparam int unsigned LenW   = $clog2(MaxLen + 1);
  localparam logic [LenW-1:0] NameMax = LenW'(MAX_NAME_LEN);
  localparam logic [LenW-1:0] StrMax  = LenW'(MAX_STRING_LEN);

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_NAME    = 3'd2,
    MODE_INT     = 3'd3,
    MODE_STR     = 3'd4,
    MODE_ESC     = 3'd5,
    MODE_ERR     = 3'd6
  } mode_e;

  typedef struct packed {
    logic [2:0]           kind;
    logic                 has_char;
    logic [7:0]           ch;
    logic [IntW-1:0]      ival;
    logic [LINE_BITS-1:0] line;
    logic [COL_BITS-1:0]  col;
    logic [2:0]           err;
    logic                 last;
  } item_t;

  localparam int unsigned ItemW = $bits(item_t);

  function automatic item_t mk_item(logic [2:0] kind, logic has, logic [7:0] ch,
                                    logic [IntW-1:0] ival, logic [LINE_BITS-1:0] line,
                                    logic [COL_BITS-1:0] col, logic [2:0] err,
                                    logic last);
    item_t it;
    it.kind     = kind;
    it.has_char = has;
    it.ch       = ch;
    it.ival     = ival;
    it.line     = line;
    it.col      = col;
    it.err      = err;
    it.last     = last;
    return it;
  endfunction

  mode_e                mode_q, mode_d;
  logic [LINE_BITS-1:0] cur_line_q, cur_line_d, start_line_q, start_line_d;
  logic [COL_BITS-1:0]  cur_col_q, cur_col_d, start_col_q, start_col_d;
  logic [IntW-1:0]      acc_q, acc_d;
  logic [LenW-1:0]      len_q, len_d;
  logic [2:0]           err_code_q, err_code_d;
  logic [LINE_BITS-1:0] err_line_q, err_line_d;
  logic [COL_BITS-1:0]  err_col_q, err_col_d;

  item_t      it0, it1, head;
  logic       v0, v1;
  logic [1:0] push_cnt;
  logic       room;
  logic       fifo_valid;
  logic [ItemW-1:0] fifo_dout;

  // idle-mode outcome of the current byte
  mode_e           id_mode;
  logic            id_nl, id_start, id_item_v, id_err, id_len_set, id_acc_set;
  item_t           id_item;
  logic [LenW-1:0] id_len;

  logic [IntW+3:0] acc_x10;
  logic [IntW-1:0] acc_next;
  logic            esc_ok;
  logic [7:0]      esc_ch;
  logic            apply_idle, str_push, pos_upd, newline;
  logic [7:0]      str_ch;
  logic [LINE_BITS-1:0] line_inc;
  logic [COL_BITS-1:0]  col_inc;

  assign take_o = item_valid_i && room;

  // accumulate times ten by shifts, saturating to 31 bits
  assign acc_x10  = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + (IntW + 4)'(byte_i[3:0]);
  assign acc_next = (|acc_x10[IntW+3:IntW]) ? '1 : acc_x10[IntW-1:0];

  assign line_inc = (cur_line_q == '1) ? cur_line_q : cur_line_q + LINE_BITS'(1);
  assign col_inc  = (cur_col_q == '1) ? cur_col_q : cur_col_q + COL_BITS'(1);

  always_comb begin
    esc_ok = 1'b1;
    case (byte_i)
      CH_LOW_N: esc_ch = CH_LF;
      CH_LOW_T: esc_ch = CH_TAB;
      CH_BSLASH, CH_QUOTE: esc_ch = byte_i;
      default: begin
        esc_ch = byte_i;
        esc_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    id_mode    = MODE_IDLE;
    id_nl      = 1'b0;
    id_start   = 1'b0;
    id_item_v  = 1'b0;
    id_item    = '0;
    id_err     = 1'b0;
    id_len_set = 1'b0;
    id_len     = '0;
    id_acc_set = 1'b0;
    if (cls_i.lf) begin
      id_nl = 1'b1;
    end else if (cls_i.space) begin
      id_mode = MODE_IDLE;
    end else if (cls_i.hash) begin
      id_mode = MODE_COMMENT;
    end else begin
      id_start = 1'b1;
      if (cls_i.quote) begin
        id_mode    = MODE_STR;
        id_len_set = 1'b1;
      end else if (cls_i.alpha) begin
        id_mode    = MODE_NAME;
        id_len_set = 1'b1;
        id_len     = LenW'(1);
        id_item_v  = 1'b1;
        id_item    = mk_item(KIND_NAME, 1'b1, byte_i, '0, cur_line_q, cur_col_q, '0, 1'b0);
      end else if (cls_i.digit) begin
        id_mode    = MODE_INT;
        id_acc_set = 1'b1;
      end else if (cls_i.punct) begin
        id_item_v = 1'b1;
        id_item   = mk_item(KIND_PUNCT, 1'b1, byte_i, '0, cur_line_q, cur_col_q, '0, 1'b1);
      end else begin
        id_mode   = MODE_ERR;
        id_err    = 1'b1;
        id_item_v = 1'b1;
        id_item   = mk_item(KIND_ERR, 1'b0, '0, '0, cur_line_q, cur_col_q,
                            ERR_UNEXPECTED, 1'b1);
      end
    end
  end

  always_comb begin
    mode_d       = mode_q;
    cur_line_d   = cur_line_q;
    cur_col_d    = cur_col_q;
    start_line_d = start_line_q;
    start_col_d  = start_col_q;
    acc_d        = acc_q;
    len_d        = len_q;
    err_code_d   = err_code_q;
    err_line_d   = err_line_q;
    err_col_d    = err_col_q;
    it0          = '0;
    it1          = '0;
    v0           = 1'b0;
    v1           = 1'b0;
    apply_idle   = 1'b0;
    str_push     = 1'b0;
    str_ch       = byte_i;
    pos_upd      = 1'b0;
    newline      = 1'b0;

    if (mode_q == MODE_ERR) begin
      v0  = 1'b1;
      it0 = mk_item(KIND_ERR, 1'b0, '0, '0, err_line_q, err_col_q, err_code_q, 1'b1);
    end else if (eot_i) begin
      unique case (mode_q)
        MODE_NAME: begin
          v0  = 1'b1;
          it0 = mk_item(KIND_NAME, 1'b0, '0, '0, start_line_q, start_col_q, '0, 1'b1);
        end
        MODE_INT: begin
          v0  = 1'b1;
          it0 = mk_item(KIND_INT, 1'b0, '0, acc_q, start_line_q, start_col_q, '0, 1'b1);
        end
        MODE_STR, MODE_ESC: begin
          v0         = 1'b1;
          err_code_d = (mode_q == MODE_STR) ? ERR_UNTERM : ERR_ESC_END;
          err_line_d = start_line_q;
          err_col_d  = start_col_q;
          mode_d     = MODE_ERR;
          it0        = mk_item(KIND_ERR, 1'b0, '0, '0, start_line_q, start_col_q,
                               err_code_d, 1'b1);
        end
        default: begin
          v0 = 1'b0;
        end
      endcase
      if (mode_d != MODE_ERR) begin
        // end of file comes after any flushed token
        if (v0) begin
          v1  = 1'b1;
          it1 = mk_item(KIND_EOF, 1'b0, '0, '0, cur_line_q, COL_BITS'(1), '0, 1'b1);
        end else begin
          v0  = 1'b1;
          it0 = mk_item(KIND_EOF, 1'b0, '0, '0, cur_line_q, COL_BITS'(1), '0, 1'b1);
        end
        mode_d     = MODE_IDLE;
        cur_line_d = LINE_BITS'(1);
        cur_col_d  = COL_BITS'(1);
        acc_d      = '0;
        len_d      = '0;
      end
    end else begin
      pos_upd = 1'b1;
      unique case (mode_q)
        MODE_COMMENT: begin
          apply_idle = cls_i.lf;
        end
        MODE_NAME: begin
          if (cls_i.alpha || cls_i.digit) begin
            if (len_q >= NameMax) begin
              v0         = 1'b1;
              mode_d     = MODE_ERR;
              err_code_d = ERR_NAME_LONG;
              err_line_d = start_line_q;
              err_col_d  = start_col_q;
              it0        = mk_item(KIND_ERR, 1'b0, '0, '0, start_line_q, start_col_q,
                                   ERR_NAME_LONG, 1'b1);
            end else begin
              v0    = 1'b1;
              len_d = len_q + LenW'(1);
              it0   = mk_item(KIND_NAME, 1'b1, byte_i, '0, start_line_q, start_col_q,
                              '0, 1'b0);
            end
          end else begin
            v0         = 1'b1;
            it0        = mk_item(KIND_NAME, 1'b0, '0, '0, start_line_q, start_col_q,
                                 '0, 1'b1);
            apply_idle = 1'b1;
          end
        end
        MODE_INT: begin
          if (cls_i.digit) begin
            acc_d = acc_next;
          end else begin
            v0         = 1'b1;
            it0        = mk_item(KIND_INT, 1'b0, '0, acc_q, start_line_q, start_col_q,
                                 '0, 1'b1);
            apply_idle = 1'b1;
          end
        end
        MODE_STR: begin
          if (cls_i.quote) begin
            v0     = 1'b1;
            it0    = mk_item(KIND_STR, 1'b0, '0, '0, start_line_q, start_col_q, '0, 1'b1);
            mode_d = MODE_IDLE;
          end else if (cls_i.bslash) begin
            mode_d = MODE_ESC;
          end else begin
            str_push = 1'b1;
          end
        end
        MODE_ESC: begin
          if (esc_ok) begin
            str_push = 1'b1;
            str_ch   = esc_ch;
          end else begin
            v0         = 1'b1;
            mode_d     = MODE_ERR;
            err_code_d = ERR_BAD_ESC;
            err_line_d = start_line_q;
            err_col_d  = start_col_q;
            it0        = mk_item(KIND_ERR, 1'b0, '0, '0, start_line_q, start_col_q,
                                 ERR_BAD_ESC, 1'b1);
          end
        end
        default: begin
          apply_idle = 1'b1;
        end
      endcase
    end

    if (str_push) begin
      v0 = 1'b1;
      if (len_q >= StrMax) begin
        mode_d     = MODE_ERR;
        err_code_d = ERR_STR_LONG;
        err_line_d = start_line_q;
        err_col_d  = start_col_q;
        it0        = mk_item(KIND_ERR, 1'b0, '0, '0, start_line_q, start_col_q,
                             ERR_STR_LONG, 1'b1);
      end else begin
        mode_d = MODE_STR;
        len_d  = len_q + LenW'(1);
        it0    = mk_item(KIND_STR, 1'b1, str_ch, '0, start_line_q, start_col_q, '0, 1'b0);
      end
    end

    if (apply_idle) begin
      mode_d  = id_mode;
      newline = id_nl;
      if (id_start) begin
        start_line_d = cur_line_q;
        start_col_d  = cur_col_q;
      end
      if (id_len_set) begin
        len_d = id_len;
      end
      if (id_acc_set) begin
        acc_d = IntW'(byte_i[3:0]);
      end
      if (id_err) begin
        err_code_d = ERR_UNEXPECTED;
        err_line_d = cur_line_q;
        err_col_d  = cur_col_q;
      end
      // a closing item already in the first slot goes out first
      if (id_item_v) begin
        if (v0) begin
          v1  = 1'b1;
          it1 = id_item;
        end else begin
          v0  = 1'b1;
          it0 = id_item;
        end
      end
    end

    if (pos_upd) begin
      if (newline) begin
        cur_line_d = line_inc;
        cur_col_d  = COL_BITS'(1);
      end else begin
        cur_col_d = col_inc;
      end
    end
  end

  assign push_cnt = take_o ? ({1'b0, v0} + {1'b0, v1}) : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_IDLE;
      cur_line_q   <= LINE_BITS'(1);
      cur_col_q    <= COL_BITS'(1);
      start_line_q <= LINE_BITS'(1);
      start_col_q  <= COL_BITS'(1);
      acc_q        <= '0;
      len_q        <= '0;
      err_code_q   <= '0;
      err_line_q   <= '0;
      err_col_q    <= '0;
    end else if (take_o) begin
      mode_q       <= mode_d;
      cur_line_q   <= cur_line_d;
      cur_col_q    <= cur_col_d;
      start_line_q <= start_line_d;
      start_col_q  <= start_col_d;
      acc_q        <= acc_d;
      len_q        <= len_d;
      err_code_q   <= err_code_d;
      err_line_q   <= err_line_d;
      err_col_q    <= err_col_d;
    end
  end

  stl_res_fifo #(
    .DATA_W (ItemW)
  ) u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .data0_i     (it0),
    .data1_i     (it1),
    .room_o      (room),
    .out_valid_o (fifo_valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (fifo_dout)
  );

  assign head             = fifo_dout;
  assign out_o.valid      = fifo_valid;
  assign out_o.token_kind = head.kind;
  assign out_o.has_char   = head.has_char;
  assign out_o.char_out   = head.ch;
  assign out_o.int_value  = head.ival;
  assign out_o.tok_line   = head.line;
  assign out_o.tok_col    = head.col;
  assign out_o.err_code   = head.err;
  assign out_o.tok_last   = head.last;

  `STL_ASSERT_NEXT(a_err_sticky, clk_i, rst_ni, mode_q == MODE_ERR, mode_q == MODE_ERR)
  `STL_ASSERT_IMP(a_err_single, clk_i, rst_ni, take_o && (mode_q == MODE_ERR),
                  (push_cnt == 2'd1) && (it0.kind == KIND_ERR))
  `STL_ASSERT(a_pos_nonzero, clk_i, rst_ni, (cur_line_q != '0) && (cur_col_q != '0))

endmodule

`default_nettype wire

// File: rtl/core/source_text_lexer.sv
// source text lexer top level: input register, classifier and lexer core
//
// in_i carries one source byte, or an end-of-text marker, per transaction;
// out_o carries one token result per transaction. A byte gives up to two
// results: a closing item for a pending token, then its own item. Name and
// string characters come out one per result as they arrive, followed by a
// closing result; integers come out as one result when ended by a non-digit
// or end of text. After any error every transaction returns the same error
// result until reset. Throughput: one byte per cycle while the result queue
// has room for a pair; a byte that gives two results writes both at once.
// The byte is held in the input register while the step logic writes its
// results into the result queue, from whose head the output port offers
// them one at a time.
// A four-entry result queue separates the two sides; input is held off only
// when fewer than two entries are free, so a stalled receiver backs up the
// input once more than two results wait. Reset clears the lexer state to idle at
// line 1, column 1 and empties the queue; no clearing pass is needed.
`default_nettype none

module source_text_lexer
  import stl_pkg::*;
#(
  parameter int unsigned MAX_NAME_LEN   = 255,
  parameter int unsigned MAX_STRING_LEN = 4095,
  parameter int unsigned LINE_BITS      = 20,
  parameter int unsigned COL_BITS       = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  stl_in_if.sink    in_i,
  stl_out_if.source out_o
);

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_eot_q;
  logic       take;
  class_t     cls;

  assign in_i.ready = !in_vld_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.byte_in;
      in_eot_q  <= in_i.end_of_text;
    end
  end

  stl_class u_class (
    .byte_i (in_byte_q),
    .cls_o  (cls)
  );

  stl_core #(
    .MAX_NAME_LEN   (MAX_NAME_LEN),
    .MAX_STRING_LEN (MAX_STRING_LEN),
    .LINE_BITS      (LINE_BITS),
    .COL_BITS       (COL_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_vld_q),
    .byte_i       (in_byte_q),
    .eot_i        (in_eot_q),
    .cls_i        (cls),
    .take_o       (take),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire
